@@ design/tcc_pkg.sv @@
// shared types, constants and lookup functions for the terminal cell color resolver
// no dependencies; used by tcc_prep, tcc_expand and the top level
package tcc_pkg;

  localparam int unsigned CodeWidth = 25;
  localparam int unsigned ChanWidth = 16;

  // palette code ranges
  localparam logic [7:0] BasicLast = 8'd15;
  localparam logic [7:0] CubeFirst = 8'd16;
  localparam logic [7:0] CubeLast  = 8'd231;
  localparam logic [7:0] RampFirst = 8'd232;
  localparam logic [7:0] RampBase  = 8'h08;
  localparam logic [7:0] RampStep  = 8'h0A;
  localparam logic [7:0] CubeBase  = 8'h37;
  localparam logic [7:0] CubeStep  = 8'h28;

  // fixed gray codes 256..259 and the unknown-code defaults
  localparam logic [1:0] FixedGrayLight = 2'd0;
  localparam logic [1:0] FixedGrayDark  = 2'd1;
  localparam logic [1:0] FixedGrayFg    = 2'd2;
  localparam logic [1:0] FixedBlack     = 2'd3;
  localparam logic [7:0] ByteLight   = 8'hCC;
  localparam logic [7:0] ByteDark    = 8'h55;
  localparam logic [7:0] ByteDefault = 8'hE5;

  // how a prepared color still has to be finished
  typedef enum logic [0:0] {
    KIND_BYTES,
    KIND_CUBE
  } tcc_kind_e;

  // one color after classification: three bytes, or three cube levels in the low bits
  typedef struct packed {
    tcc_kind_e  kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tcc_prep_t;

  // 16-color ANSI table, red in the top byte
  localparam logic [23:0] BasicTable [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  // cube level to byte: zero stays zero, otherwise base plus step per level
  function automatic logic [7:0] cube_byte(input logic [2:0] level);
    logic [7:0] b;
    case (level)
      3'd0:    b = 8'h00;
      3'd1:    b = CubeBase + CubeStep;
      3'd2:    b = CubeBase + 8'(2 * CubeStep);
      3'd3:    b = CubeBase + 8'(3 * CubeStep);
      3'd4:    b = CubeBase + 8'(4 * CubeStep);
      3'd5:    b = CubeBase + 8'(5 * CubeStep);
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ design/terminal_cell_color_resolver_core.sv @@
// pipeline: an accepted input beat passes through the s1, s2 and output registers
// throughput: one beat per cycle while the output is not stalled; a three-register pipeline with valid bits per stage
// stall on the output backs up stage by stage, bubbles are filled, nothing dropped
// reset: rst_ni asynchronous active low clears all stage valid bits
// depends on tcc_pkg, tcc_prep and tcc_expand
module terminal_cell_color_resolver_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tcc_pkg::CodeWidth-1:0] fg_color_i,
  input  logic [tcc_pkg::CodeWidth-1:0] bg_color_i,
  input  logic                          bold_i,
  input  logic                          faint_i,
  input  logic                          reverse_i,
  input  logic                          blink_i,
  input  logic                          invisible_i,
  input  logic                          selected_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tcc_pkg::ChanWidth-1:0] fg_red_o,
  output logic [tcc_pkg::ChanWidth-1:0] fg_green_o,
  output logic [tcc_pkg::ChanWidth-1:0] fg_blue_o,
  output logic [tcc_pkg::ChanWidth-1:0] bg_red_o,
  output logic [tcc_pkg::ChanWidth-1:0] bg_green_o,
  output logic [tcc_pkg::ChanWidth-1:0] bg_blue_o
);

  logic s1_ready, s2_ready, s3_ready;

  logic                          s1_valid_q;
  logic [tcc_pkg::CodeWidth-1:0] s1_fg_q, s1_fg_d;
  logic [tcc_pkg::CodeWidth-1:0] s1_bg_q, s1_bg_d;
  logic                          s1_faint_q;

  logic                          s2_valid_q;
  tcc_pkg::tcc_prep_t            s2_fg_q, s2_fg_d;
  tcc_pkg::tcc_prep_t            s2_bg_q, s2_bg_d;
  logic                          s2_faint_q;

  logic                          out_valid_q;
  logic [tcc_pkg::ChanWidth-1:0] fg_r_d, fg_g_d, fg_b_d, bg_r_d, bg_g_d, bg_b_d;
  logic [tcc_pkg::ChanWidth-1:0] fg_r_q, fg_g_q, fg_b_q, bg_r_q, bg_g_q, bg_b_q;

  // stage handshake chain
  assign s3_ready   = !out_valid_q || !out_stall_i;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_stall_o = !s1_ready;

  // stage 1: bold, swaps, and blink or invisible on the codes
  always_comb begin
    logic [tcc_pkg::CodeWidth-1:0] fg, bg, t;
    fg = fg_color_i;
    bg = bg_color_i;
    t  = fg_color_i;
    if (bold_i && !faint_i && fg <= tcc_pkg::CodeWidth'(7)) begin
      fg = fg + tcc_pkg::CodeWidth'(8);
    end
    if (reverse_i) begin
      t  = fg;
      fg = bg;
      bg = t;
    end
    if (selected_i) begin
      t  = fg;
      fg = bg;
      bg = t;
    end
    if (blink_i || invisible_i) begin
      fg = bg;
    end
    s1_fg_d = fg;
    s1_bg_d = bg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_fg_q    <= s1_fg_d;
      s1_bg_q    <= s1_bg_d;
      s1_faint_q <= faint_i;
    end
  end

  // stage 2: classify both codes
  tcc_prep u_prep_fg (
    .code_i  (s1_fg_q),
    .as_bg_i (1'b0),
    .prep_o  (s2_fg_d)
  );

  tcc_prep u_prep_bg (
    .code_i  (s1_bg_q),
    .as_bg_i (1'b1),
    .prep_o  (s2_bg_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s2_ready) begin
      s2_fg_q    <= s2_fg_d;
      s2_bg_q    <= s2_bg_d;
      s2_faint_q <= s1_faint_q;
    end
  end

  // stage 3: widen to 16 bits, faint halves the foreground
  tcc_expand u_expand_fg (
    .prep_i  (s2_fg_q),
    .half_i  (s2_faint_q),
    .red_o   (fg_r_d),
    .green_o (fg_g_d),
    .blue_o  (fg_b_d)
  );

  tcc_expand u_expand_bg (
    .prep_i  (s2_bg_q),
    .half_i  (1'b0),
    .red_o   (bg_r_d),
    .green_o (bg_g_d),
    .blue_o  (bg_b_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s3_ready) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      fg_r_q <= fg_r_d;
      fg_g_q <= fg_g_d;
      fg_b_q <= fg_b_d;
      bg_r_q <= bg_r_d;
      bg_g_q <= bg_g_d;
      bg_b_q <= bg_b_d;
    end
  end

  // output beat
  assign out_valid_o = out_valid_q;
  assign fg_red_o    = fg_r_q;
  assign fg_green_o  = fg_g_q;
  assign fg_blue_o   = fg_b_q;
  assign bg_red_o    = bg_r_q;
  assign bg_green_o  = bg_g_q;
  assign bg_blue_o   = bg_b_q;

endmodule

@@ design/tcc_prep.sv @@
// classifies one color code and reduces it to three bytes or three cube levels
// depends on tcc_pkg
module tcc_prep (
  input  logic [tcc_pkg::CodeWidth-1:0] code_i,
  input  logic                          as_bg_i,
  output tcc_pkg::tcc_prep_t            prep_o
);

  logic        high_zero;
  logic [7:0]  low_byte;
  logic [7:0]  cube_idx;
  logic [13:0] prod36;
  logic [15:0] prod6;
  logic [2:0]  q36;
  logic [5:0]  q6;
  logic [5:0]  g_lvl;
  logic [7:0]  b_lvl;
  logic [4:0]  ramp_idx;
  logic [7:0]  ramp_byte;
  logic [7:0]  fixed_byte;
  logic [23:0] basic_rgb;

  assign high_zero = (code_i[23:8] == 16'd0);
  assign low_byte  = code_i[7:0];

  // cube index split by reciprocal multiply, exact for index below 216
  assign cube_idx = low_byte - tcc_pkg::CubeFirst;
  assign prod36   = 14'(cube_idx) * 14'd57;
  assign prod6    = 16'(cube_idx) * 16'd171;
  assign q36      = prod36[13:11];
  assign q6       = prod6[15:10];
  assign g_lvl    = q6 - 6'(6 * q36);
  assign b_lvl    = cube_idx - 8'(6 * q6);

  // gray ramp byte
  assign ramp_idx  = 5'(low_byte - tcc_pkg::RampFirst);
  assign ramp_byte = tcc_pkg::RampBase + 8'(ramp_idx * tcc_pkg::RampStep);

  assign basic_rgb = tcc_pkg::BasicTable[low_byte[3:0]];

  // fixed grays and the unknown default
  always_comb begin
    if (code_i[23:2] == 22'd64) begin
      case (code_i[1:0])
        tcc_pkg::FixedGrayLight: fixed_byte = tcc_pkg::ByteLight;
        tcc_pkg::FixedGrayDark:  fixed_byte = tcc_pkg::ByteDark;
        tcc_pkg::FixedGrayFg:    fixed_byte = tcc_pkg::ByteDefault;
        tcc_pkg::FixedBlack:     fixed_byte = 8'h00;
        default:                 fixed_byte = 8'h00;
      endcase
    end else begin
      fixed_byte = as_bg_i ? 8'h00 : tcc_pkg::ByteDefault;
    end
  end

  // class select
  always_comb begin
    prep_o.kind = tcc_pkg::KIND_BYTES;
    if (code_i[24]) begin
      prep_o.red   = code_i[23:16];
      prep_o.green = code_i[15:8];
      prep_o.blue  = code_i[7:0];
    end else if (high_zero && low_byte <= tcc_pkg::BasicLast) begin
      prep_o.red   = basic_rgb[23:16];
      prep_o.green = basic_rgb[15:8];
      prep_o.blue  = basic_rgb[7:0];
    end else if (high_zero && low_byte <= tcc_pkg::CubeLast) begin
      prep_o.kind  = tcc_pkg::KIND_CUBE;
      prep_o.red   = {5'd0, q36};
      prep_o.green = {5'd0, g_lvl[2:0]};
      prep_o.blue  = {5'd0, b_lvl[2:0]};
    end else if (high_zero) begin
      prep_o.red   = ramp_byte;
      prep_o.green = ramp_byte;
      prep_o.blue  = ramp_byte;
    end else begin
      prep_o.red   = fixed_byte;
      prep_o.green = fixed_byte;
      prep_o.blue  = fixed_byte;
    end
  end

endmodule

@@ design/tcc_expand.sv @@
// turns a prepared color into 16-bit channels, with optional halving
// depends on tcc_pkg
module tcc_expand (
  input  tcc_pkg::tcc_prep_t            prep_i,
  input  logic                          half_i,
  output logic [tcc_pkg::ChanWidth-1:0] red_o,
  output logic [tcc_pkg::ChanWidth-1:0] green_o,
  output logic [tcc_pkg::ChanWidth-1:0] blue_o
);

  logic [7:0] r_byte;
  logic [7:0] g_byte;
  logic [7:0] b_byte;

  // cube levels go through the level table, everything else is a byte already
  always_comb begin
    case (prep_i.kind)
      tcc_pkg::KIND_CUBE: begin
        r_byte = tcc_pkg::cube_byte(prep_i.red[2:0]);
        g_byte = tcc_pkg::cube_byte(prep_i.green[2:0]);
        b_byte = tcc_pkg::cube_byte(prep_i.blue[2:0]);
      end
      default: begin
        r_byte = prep_i.red;
        g_byte = prep_i.green;
        b_byte = prep_i.blue;
      end
    endcase
  end

  // widen by byte repeat, halve on request
  assign red_o   = half_i ? {1'b0, r_byte, r_byte[7:1]} : {r_byte, r_byte};
  assign green_o = half_i ? {1'b0, g_byte, g_byte[7:1]} : {g_byte, g_byte};
  assign blue_o  = half_i ? {1'b0, b_byte, b_byte[7:1]} : {b_byte, b_byte};

endmodule

@@ tb/terminal_cell_color_resolver_core_test.sv @@
// self-checking bench for terminal_cell_color_resolver_core: random and directed cells,
// colors predicted in-bench and compared per channel; depends on tcc_pkg and the core rtl
module terminal_cell_color_resolver_core_test;

  localparam int unsigned CycleLimit   = 50000;
  localparam int unsigned RandomCells  = 650;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted   = 50;

  // code points and flags
  localparam logic [24:0] TrueRgbFlag = 25'h1000000;
  localparam logic [24:0] CodeLight   = 25'd256;
  localparam logic [24:0] CodeDark    = 25'd257;
  localparam logic [24:0] CodeDefault = 25'd258;
  localparam logic [24:0] CodeBlack   = 25'd259;
  localparam logic [15:0] GrayLight   = 16'hCCCC;
  localparam logic [15:0] GrayDark    = 16'h5555;
  localparam logic [15:0] GrayDefault = 16'hE5E5;
  localparam logic [15:0] RampBase16  = 16'h0808;
  localparam logic [15:0] RampStep16  = 16'h0A0A;

  // attribute masks, same order as the flag fields of cell_attr_t
  localparam logic [5:0] AttrNone     = 6'b000000;
  localparam logic [5:0] AttrBold     = 6'b100000;
  localparam logic [5:0] AttrFaint    = 6'b010000;
  localparam logic [5:0] AttrReverse  = 6'b001000;
  localparam logic [5:0] AttrBlink    = 6'b000100;
  localparam logic [5:0] AttrHidden   = 6'b000010;
  localparam logic [5:0] AttrSelected = 6'b000001;

  localparam logic [23:0] AnsiRgb [16] = '{
    24'h000000, 24'hCD0000, 24'h00CD00, 24'hCDCD00,
    24'h0000EE, 24'hCD00CD, 24'h00CDCD, 24'hE5E5E5,
    24'h7F7F7F, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h5C5CFF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  typedef struct packed {
    logic [24:0] fg_code;
    logic [24:0] bg_code;
    logic        bold;
    logic        faint;
    logic        reverse;
    logic        blink;
    logic        invisible;
    logic        selected;
  } cell_attr_t;

  typedef logic [0:2][15:0] rgb_t;
  typedef logic [0:5][15:0] cell_rgb_t;

  string chan_name [6] = '{"fg_red", "fg_green", "fg_blue", "bg_red", "bg_green", "bg_blue"};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        out_stall_i = 1'b0;
  logic [24:0] fg_color_i  = '0;
  logic [24:0] bg_color_i  = '0;
  logic        bold_i      = 1'b0;
  logic        faint_i     = 1'b0;
  logic        reverse_i   = 1'b0;
  logic        blink_i     = 1'b0;
  logic        invisible_i = 1'b0;
  logic        selected_i  = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [15:0] fg_red_o, fg_green_o, fg_blue_o, bg_red_o, bg_green_o, bg_blue_o;

  cell_attr_t  cells_to_send [$];
  cell_rgb_t   cell_rgb_due [$];
  cell_attr_t  cell_on_bus;
  int unsigned cells_sent   = 0;
  int unsigned cells_seen   = 0;
  int unsigned fault_count  = 0;
  int unsigned cycle_count  = 0;

  terminal_cell_color_resolver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .fg_color_i  (fg_color_i),
    .bg_color_i  (bg_color_i),
    .bold_i      (bold_i),
    .faint_i     (faint_i),
    .reverse_i   (reverse_i),
    .blink_i     (blink_i),
    .invisible_i (invisible_i),
    .selected_i  (selected_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .fg_red_o    (fg_red_o),
    .fg_green_o  (fg_green_o),
    .fg_blue_o   (fg_blue_o),
    .bg_red_o    (bg_red_o),
    .bg_green_o  (bg_green_o),
    .bg_blue_o   (bg_blue_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // one cube level to a 16-bit channel
  function automatic logic [15:0] cube_chan(input int unsigned level);
    return (level == 0) ? 16'h0000 : 16'(32'h3737 + 32'h2828 * level);
  endfunction

  // color code to rgb; unknown codes depend on the final position
  function automatic rgb_t decode_color(input logic [24:0] code, input bit as_bg);
    rgb_t        c;
    int unsigned idx;
    logic [23:0] ansi;
    logic [15:0] ramp;
    if (code[24]) begin
      c = {{2{code[23:16]}}, {2{code[15:8]}}, {2{code[7:0]}}};
    end else if (code < 25'd16) begin
      ansi = AnsiRgb[code[3:0]];
      c = {{2{ansi[23:16]}}, {2{ansi[15:8]}}, {2{ansi[7:0]}}};
    end else if (code <= 25'd231) begin
      idx = 32'(code - 25'd16);
      c = {cube_chan(idx / 36), cube_chan((idx / 6) % 6), cube_chan(idx % 6)};
    end else if (code <= 25'd255) begin
      ramp = RampBase16 + 16'(code - 25'd232) * RampStep16;
      c = {3{ramp}};
    end else if (code == CodeLight) begin
      c = {3{GrayLight}};
    end else if (code == CodeDark) begin
      c = {3{GrayDark}};
    end else if (code == CodeDefault) begin
      c = {3{GrayDefault}};
    end else if (code == CodeBlack) begin
      c = '0;
    end else begin
      c = as_bg ? '0 : {3{GrayDefault}};
    end
    return c;
  endfunction

  // brighten, swap, hide, decode, then dim the foreground
  function automatic cell_rgb_t resolve_cell(input cell_attr_t c);
    logic [24:0] fg, bg, t;
    rgb_t        f, b;
    fg = c.fg_code;
    bg = c.bg_code;
    if (c.bold && !c.faint && fg <= 25'd7) fg = fg + 25'd8;
    if (c.reverse) begin
      t = fg; fg = bg; bg = t;
    end
    if (c.selected) begin
      t = fg; fg = bg; bg = t;
    end
    if (c.blink || c.invisible) fg = bg;
    f = decode_color(fg, 1'b0);
    b = decode_color(bg, 1'b1);
    if (c.faint) f = {f[0] >> 1, f[1] >> 1, f[2] >> 1};
    return {f, b};
  endfunction

  function automatic cell_attr_t pack_cell(input logic [24:0] fg, input logic [24:0] bg,
                                           input logic [5:0] attrs);
    return {fg, bg, attrs};
  endfunction

  // code drawn from every decoding region, plus raw 25-bit noise
  function automatic logic [24:0] random_code();
    logic [24:0] code;
    case ($urandom_range(0, 8))
      0:       code = 25'($urandom_range(0, 7));
      1:       code = 25'($urandom_range(8, 15));
      2:       code = 25'($urandom_range(16, 231));
      3:       code = 25'($urandom_range(232, 255));
      4:       code = 25'($urandom_range(256, 259));
      5:       code = 25'($urandom_range(260, 24'hFFFFFF));
      6, 7:    code = TrueRgbFlag | 25'($urandom & 32'hFFFFFF);
      default: code = 25'($urandom);
    endcase
    return code;
  endfunction

  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= MaxPrinted) $display("ERROR: %s", msg);
  endtask

  task automatic wait_drained();
    while (cells_to_send.size() != 0 || in_valid_i || cell_rgb_due.size() != 0)
      @(posedge clk_i);
  endtask

  // driver: hold a stalled beat, otherwise load the next cell or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        cell_rgb_due.push_back(resolve_cell(cell_on_bus));
        cells_sent++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (cells_to_send.size() != 0 &&
            ((cells_sent >= 400 && cells_sent < 550) || $urandom_range(0, 99) >= 16)) begin
          cell_on_bus = cells_to_send.pop_front();
          fg_color_i  <= cell_on_bus.fg_code;
          bg_color_i  <= cell_on_bus.bg_code;
          bold_i      <= cell_on_bus.bold;
          faint_i     <= cell_on_bus.faint;
          reverse_i   <= cell_on_bus.reverse;
          blink_i     <= cell_on_bus.blink;
          invisible_i <= cell_on_bus.invisible;
          selected_i  <= cell_on_bus.selected;
          in_valid_i  <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor: match beats to oldest prediction, stall at random outside beats 400..549
  always @(posedge clk_i) begin
    cell_rgb_t got, want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {fg_red_o, fg_green_o, fg_blue_o, bg_red_o, bg_green_o, bg_blue_o};
        if (cell_rgb_due.size() == 0) begin
          note_fault($sformatf("output beat with no cell pending, cycle %0d", cycle_count));
        end else begin
          want = cell_rgb_due.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got[i] !== want[i])
              note_fault($sformatf("beat %0d %s: got %h, want %h",
                                   cells_seen, chan_name[i], got[i], want[i]));
          end
        end
        cells_seen++;
      end
      out_stall_i <= !(cells_seen >= 400 && cells_seen < 550) && ($urandom_range(0, 99) < 16);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    cell_attr_t c;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed cells: extremes, each attribute and the corner cases
    cells_to_send.push_back(pack_cell(25'd0, 25'd0, AttrNone));
    cells_to_send.push_back(pack_cell(25'h1FFFFFF, 25'h1FFFFFF, 6'b111111));
    cells_to_send.push_back(pack_cell(25'd7, 25'd0, AttrBold));
    cells_to_send.push_back(pack_cell(25'd8, 25'd1, AttrBold));
    cells_to_send.push_back(pack_cell(25'd3, 25'd4, AttrBold | AttrFaint));
    cells_to_send.push_back(pack_cell(TrueRgbFlag | 25'h123456, 25'd5, AttrBold));
    cells_to_send.push_back(pack_cell(25'd260, 25'd260, AttrNone));
    cells_to_send.push_back(pack_cell(25'hFFFFFF, 25'd300, AttrReverse));
    cells_to_send.push_back(pack_cell(25'd1000, 25'd2, AttrFaint));
    cells_to_send.push_back(pack_cell(CodeBlack, 25'd9, AttrFaint | AttrSelected));
    cells_to_send.push_back(pack_cell(25'd2, 25'd9, AttrReverse));
    cells_to_send.push_back(pack_cell(25'd2, 25'd9, AttrSelected));
    cells_to_send.push_back(pack_cell(25'd2, 25'd9, AttrReverse | AttrSelected));
    cells_to_send.push_back(pack_cell(25'd2, 25'd9, AttrBlink));
    cells_to_send.push_back(pack_cell(25'd2, 25'd9, AttrHidden));
    cells_to_send.push_back(pack_cell(25'd16, 25'd231, AttrNone));
    cells_to_send.push_back(pack_cell(25'd232, 25'd255, AttrNone));
    cells_to_send.push_back(pack_cell(CodeLight, CodeDark, AttrNone));
    cells_to_send.push_back(pack_cell(CodeDefault, CodeBlack, AttrNone));
    cells_to_send.push_back(pack_cell(CodeBlack, CodeDefault, AttrFaint));
    cells_to_send.push_back(pack_cell(TrueRgbFlag | 25'hFFFFFF, TrueRgbFlag,
                                      AttrReverse | AttrFaint));
    cells_to_send.push_back(pack_cell(25'd12, 25'd100, AttrBold | AttrSelected | AttrBlink));
    cells_to_send.push_back(pack_cell(25'd4, 25'd300, AttrBlink));
    cells_to_send.push_back(pack_cell(25'd0, 25'd6, AttrBold | AttrReverse));
    // stimulus holds off until every directed cell has come back
    wait_drained();

    // random cells in two batches with a full drain between them
    for (int batch = 0; batch < 2; batch++) begin
      for (int n = 0; n < RandomCells / 2; n++) begin
        c.fg_code   = random_code();
        c.bg_code   = random_code();
        c.bold      = 1'($urandom_range(0, 1));
        c.faint     = ($urandom_range(0, 3) == 0);
        c.reverse   = 1'($urandom_range(0, 1));
        c.blink     = ($urandom_range(0, 3) == 0);
        c.invisible = ($urandom_range(0, 3) == 0);
        c.selected  = 1'($urandom_range(0, 1));
        cells_to_send.push_back(c);
      end
      wait_drained();
    end

    repeat (SettleCycles) @(posedge clk_i);
    if (cell_rgb_due.size() != 0)
      note_fault($sformatf("%0d cells never came out", cell_rgb_due.size()));
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ terminal_cell_color_resolver_core.f @@
design/tcc_pkg.sv
design/tcc_prep.sv
design/tcc_expand.sv
design/terminal_cell_color_resolver_core.sv
tb/terminal_cell_color_resolver_core_test.sv
